// ===== rtl/ufd_pkg.sv =====
// Shared types and constants for the UART frame decoder.
`default_nettype none
package ufd_pkg;

    localparam int FRAME_BITS    = 10;
    localparam int DATA_BITS     = 8;
    localparam int COUNT_WIDTH   = 16;
    localparam int IDX_WIDTH     = 4;
    localparam int SKIP_WIDTH    = 20;
    localparam int ELAPSED_WIDTH = 21;

    localparam logic [COUNT_WIDTH-1:0] SPB_RESET = COUNT_WIDTH'(868);

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_RECV = 2'd1,
        MODE_SKIP = 2'd2
    } rx_mode_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] data_byte;
        logic                 frame_valid;
    } ufd_result_t;

endpackage
`default_nettype wire

// ===== rtl/ufd_rx.sv =====
// Frame timing and bit checking: one line sample per step.
`default_nettype none
module ufd_rx import ufd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step_en,
    input  wire logic                   line_level,
    input  wire logic [COUNT_WIDTH-1:0] samples_per_bit,
    output logic                        res_valid,
    output ufd_result_t                 res
);

    rx_mode_t                   mode_reg,  mode_next;
    logic                       prev_reg,  prev_next;
    logic [COUNT_WIDTH-1:0]     cnt_reg,   cnt_next;
    logic [IDX_WIDTH-1:0]       idx_reg,   idx_next;
    logic                       level_reg, level_next;
    logic [DATA_BITS-1:0]       shift_reg, shift_next;
    logic [SKIP_WIDTH-1:0]      skip_reg,  skip_next;

    logic [COUNT_WIDTH-1:0]     per;
    logic                       start;
    logic                       active;
    logic [COUNT_WIDTH-1:0]     cnt_c;
    logic [IDX_WIDTH-1:0]       idx_c;
    logic [DATA_BITS-1:0]       shift_c;
    logic                       blvl;
    logic [COUNT_WIDTH-1:0]     cnt_inc;
    logic [IDX_WIDTH-1:0]       idx_inc;
    logic [DATA_BITS-1:0]       shift_upd;
    logic [ELAPSED_WIDTH-1:0]   elapsed;
    logic [ELAPSED_WIDTH-1:0]   total;
    logic [SKIP_WIDTH-1:0]      left;
    logic [SKIP_WIDTH-1:0]      skip_dec;

    // A zero period behaves as one sample per bit.
    assign per = (samples_per_bit == '0) ? COUNT_WIDTH'(1) : samples_per_bit;

    always_comb begin
        start   = 1'b0;
        active  = 1'b0;
        unique case (mode_reg)
            MODE_RECV: active = 1'b1;
            MODE_SKIP: active = 1'b0;
            default: begin
                start  = prev_reg && !line_level;
                active = start;
            end
        endcase

        cnt_c   = start ? '0 : cnt_reg;
        idx_c   = start ? '0 : idx_reg;
        shift_c = start ? '0 : shift_reg;
        blvl    = (cnt_c == '0) ? line_level : level_reg;
        cnt_inc = cnt_c + COUNT_WIDTH'(1);
        idx_inc = idx_c + IDX_WIDTH'(1);
        shift_upd = (idx_c >= IDX_WIDTH'(1) && idx_c <= IDX_WIDTH'(DATA_BITS))
                  ? {blvl, shift_c[DATA_BITS-1:1]} : shift_c;

        elapsed = ELAPSED_WIDTH'(idx_c) * ELAPSED_WIDTH'(per)
                + ELAPSED_WIDTH'(cnt_c) + ELAPSED_WIDTH'(1);
        total   = ELAPSED_WIDTH'(FRAME_BITS) * ELAPSED_WIDTH'(per);
        left    = (elapsed >= total) ? '0 : SKIP_WIDTH'(total - elapsed);
        skip_dec = (skip_reg != '0) ? skip_reg - SKIP_WIDTH'(1) : skip_reg;

        mode_next  = mode_reg;
        prev_next  = prev_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        shift_next = shift_reg;
        skip_next  = skip_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (step_en) begin
            prev_next = line_level;
            if (active) begin
                level_next = blvl;
                if (cnt_c != '0 && line_level != level_reg) begin
                    // Line moved inside a bit: flag the frame, wait out its time.
                    res_valid  = 1'b1;
                    cnt_next   = '0;
                    idx_next   = '0;
                    shift_next = '0;
                    skip_next  = left;
                    mode_next  = (left == '0) ? MODE_HUNT : MODE_SKIP;
                end else if (cnt_inc != '0 && cnt_inc < per) begin
                    cnt_next   = cnt_inc;
                    idx_next   = idx_c;
                    shift_next = shift_c;
                    mode_next  = MODE_RECV;
                end else begin
                    cnt_next = '0;
                    if (idx_inc >= IDX_WIDTH'(FRAME_BITS)) begin
                        res_valid       = 1'b1;
                        res.data_byte   = shift_upd;
                        res.frame_valid = 1'b1;
                        idx_next   = '0;
                        shift_next = '0;
                        mode_next  = MODE_HUNT;
                    end else begin
                        idx_next   = idx_inc;
                        shift_next = shift_upd;
                        mode_next  = MODE_RECV;
                    end
                end
            end else if (mode_reg == MODE_SKIP) begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    mode_next = MODE_HUNT;
                end
            end else begin
                mode_next = MODE_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HUNT;
            prev_reg  <= 1'b1;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            level_reg <= 1'b0;
            shift_reg <= '0;
            skip_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            level_reg <= level_next;
            shift_reg <= shift_next;
            skip_reg  <= skip_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/uart_frame_decoder.sv =====
// UART 8N1 frame decoder top level: sample input stage, decoder, result queue.
// A sample that ends a frame gives its result on m_tvalid after the input register
//   and the decode into the result queue; decode waits while the queue is full.
// Throughput: 1 sample per cycle while the result queue has room.
// Reset (aresetn low, synchronous): line assumed idle high, hunting for a start
//   edge, input stage and result queue empty, samples_per_bit back to 868.
`default_nettype none
module uart_frame_decoder import ufd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Sample stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [0] line_level, [7:1] zero
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] data_byte
    output logic [0:0]                  m_tuser,   // [0] frame_valid
    // samples_per_bit register write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [COUNT_WIDTH-1:0] cfg_data
);

    // Config register
    logic [COUNT_WIDTH-1:0] spb_reg;

    // Input stage
    logic in_valid_reg, in_valid_next;
    logic in_level_reg;

    // Two-entry result queue: slot 0 drives the port, slot 1 is the skid.
    logic [1:0]  q_count_reg, q_count_next;
    ufd_result_t q0_reg, q0_next;
    ufd_result_t q1_reg, q1_next;

    logic        step_en;
    logic        rx_res_valid;
    ufd_result_t rx_res;
    logic        push;
    logic        pop;
    logic        s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg <= SPB_RESET;
        end else if (cfg_valid && cfg_ready) begin
            spb_reg <= cfg_data;
        end
    end

    // Decode runs when a sample waits and the queue has room for a result.
    assign step_en  = in_valid_reg && (q_count_reg != 2'd2);
    assign s_tready = !in_valid_reg || step_en;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg <= s_tdata[0];
        end
    end

    ufd_rx u_rx (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (step_en),
        .line_level      (in_level_reg),
        .samples_per_bit (spb_reg),
        .res_valid       (rx_res_valid),
        .res             (rx_res)
    );

    assign push     = step_en && rx_res_valid;
    assign m_tvalid = (q_count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = q0_reg.data_byte;
    assign m_tuser  = q0_reg.frame_valid;

    always_comb begin
        q_count_next = q_count_reg;
        q0_next      = q0_reg;
        q1_next      = q1_reg;
        unique case (q_count_reg)
            2'd0: begin
                if (push) begin
                    q0_next      = rx_res;
                    q_count_next = 2'd1;
                end
            end
            2'd1: begin
                if (pop && push) begin
                    q0_next = rx_res;
                end else if (pop) begin
                    q_count_next = 2'd0;
                end else if (push) begin
                    q1_next      = rx_res;
                    q_count_next = 2'd2;
                end
            end
            2'd2: begin
                // Decode is held off while full, so only a drain is possible.
                if (pop) begin
                    q0_next      = q1_reg;
                    q_count_next = 2'd1;
                end
            end
            default: q_count_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_count_reg <= 2'd0;
        end else begin
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

`ifndef SYNTH
    // A decoder result only appears on a decode step.
    a_res_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_res_valid |-> step_en)
        else $error("decoder result outside a decode step");

    // No decode step may land in a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |-> (q_count_reg != 2'd2))
        else $error("result queue overflow");

    // An invalid frame always carries a zero byte.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !rx_res.frame_valid) |-> (rx_res.data_byte == '0))
        else $error("invalid frame with nonzero byte");

    // A queued result not taken is still offered next cycle.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/uart_frame_checker.sv =====
// Checker for the UART frame decoder: frame prediction and result comparison.
`default_nettype none
module uart_frame_checker import ufd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // [0] line_level, [7:1] zero
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [7:0]             m_tdata,   // [7:0] data_byte
    input  wire logic [0:0]             m_tuser,   // [0] frame_valid
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [COUNT_WIDTH-1:0] cfg_data,
    output int                          mismatches,
    output int                          frames_pending,
    output int                          frames_checked,
    output int                          invalid_checked
);

    // Mirror of the decoder state.
    logic [COUNT_WIDTH-1:0] spb_reg;
    rx_mode_t               mode;
    logic                   prev_level;
    logic                   held_level;
    logic [COUNT_WIDTH-1:0] bit_count;
    logic [IDX_WIDTH-1:0]   bit_idx;
    logic [DATA_BITS-1:0]   shreg;
    logic [SKIP_WIDTH-1:0]  skip_left;

    ufd_result_t expected_frames[$];

    task automatic push_frame(input logic [DATA_BITS-1:0] value, input logic ok);
        ufd_result_t r;
        r.data_byte   = value;
        r.frame_valid = ok;
        expected_frames.push_back(r);
    endtask

    // One sample while a frame is timed.
    task automatic time_frame(input logic lvl);
        int unsigned per, elapsed, total;
        per = (spb_reg == '0) ? 1 : int'(spb_reg);
        if (bit_count == '0) begin
            held_level = lvl;
        end else if (lvl != held_level) begin
            // glitch inside a bit: report now, sit out the rest of the frame time
            elapsed   = int'(bit_idx) * per + int'(bit_count) + 1;
            total     = FRAME_BITS * per;
            push_frame('0, 1'b0);
            bit_count = '0;
            bit_idx   = '0;
            shreg     = '0;
            skip_left = (elapsed >= total) ? '0 : SKIP_WIDTH'(total - elapsed);
            mode      = (skip_left == '0) ? MODE_HUNT : MODE_SKIP;
            return;
        end
        bit_count = bit_count + 1'b1;
        if (bit_count != '0 && int'(bit_count) < per)
            return;
        bit_count = '0;
        if (bit_idx >= 1 && bit_idx <= DATA_BITS)
            shreg = {held_level, shreg[DATA_BITS-1:1]};
        bit_idx = bit_idx + 1'b1;
        if (bit_idx >= FRAME_BITS) begin
            push_frame(shreg, 1'b1);
            bit_idx = '0;
            shreg   = '0;
            mode    = MODE_HUNT;
        end
    endtask

    task automatic decode_sample(input logic lvl);
        if (mode == MODE_RECV) begin
            time_frame(lvl);
        end else if (mode == MODE_SKIP) begin
            if (skip_left != '0)
                skip_left = skip_left - 1'b1;
            if (skip_left == '0)
                mode = MODE_HUNT;
        end else begin
            mode = MODE_HUNT;
            if (prev_level && !lvl) begin
                mode      = MODE_RECV;
                bit_count = '0;
                bit_idx   = '0;
                shreg     = '0;
                time_frame(lvl);
            end
        end
        prev_level = lvl;
    endtask

    always @(posedge aclk) begin : watch
        ufd_result_t want;
        if (!aresetn) begin
            spb_reg    = SPB_RESET;
            mode       = MODE_HUNT;
            prev_level = 1'b1;
            held_level = 1'b0;
            bit_count  = '0;
            bit_idx    = '0;
            shreg      = '0;
            skip_left  = '0;
            expected_frames.delete();
            mismatches      = 0;
            frames_checked  = 0;
            invalid_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got data_byte %02h frame_valid %0d",
                             $time, m_tdata, m_tuser[0]);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata !== want.data_byte) begin
                        mismatches++;
                        $display("%0t: data_byte mismatch: expected %02h, got %02h",
                                 $time, want.data_byte, m_tdata);
                    end
                    if (m_tuser[0] !== want.frame_valid) begin
                        mismatches++;
                        $display("%0t: frame_valid mismatch: expected %0d, got %0d",
                                 $time, want.frame_valid, m_tuser[0]);
                    end
                    frames_checked++;
                    if (!want.frame_valid)
                        invalid_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                spb_reg = cfg_data;
            if (s_tvalid && s_tready)
                decode_sample(s_tdata[0]);
        end
        frames_pending = expected_frames.size();
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Top of the UART frame decoder testbench: clock, reset, line stimulus, verdict.
`default_nettype none
module tb_top;
    import ufd_pkg::*;

    localparam int ITEMS         = 1550;  // line samples in the whole run, roughly
    localparam int PHASE_SAMPLES = 200;   // samples per period setting in the random part
    localparam int HOLD_CYCLES   = 2000;  // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;     // covers the two-stage sample-to-result pipeline
    localparam int TAIL_CYCLES   = 8;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;   // [0] line_level, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;            // [7:0] data_byte
    logic [0:0]             m_tuser;            // [0] frame_valid
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COUNT_WIDTH-1:0] cfg_data  = '0;

    int mismatches, frames_pending, frames_checked, invalid_checked;

    // stimulus bookkeeping
    int bit_period      = 868;  // mirrors samples_per_bit as last written
    int burst_left      = 0;
    int samples_sent    = 0;
    int settings_made   = 0;
    bit hold_off_req    = 1'b0; // set by stimulus, cleared by the result sink

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    uart_frame_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    uart_frame_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .frames_pending  (frames_pending),
        .frames_checked  (frames_checked),
        .invalid_checked (invalid_checked)
    );

    // One line sample, one transaction. The sender runs in bursts of random length;
    // between bursts tvalid may drop.
    task automatic send_level(input logic lvl);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        samples_sent++;
    endtask

    task automatic send_held(input logic lvl, input int count);
        repeat (count) send_level(lvl);
    endtask

    // Frame at the current bit period, from bit from_bit on (0 = start bit).
    // flip_at >= 0 inverts the sample at that offset from the start edge.
    task automatic send_frame(input logic [7:0] value, input logic stop_level,
                              input int flip_at, input int from_bit);
        logic [FRAME_BITS-1:0] frame_word;
        logic                  lvl;
        int                    b, n;
        frame_word = {stop_level, value, 1'b0};
        for (b = from_bit; b < FRAME_BITS; b++)
            for (n = 0; n < bit_period; n++) begin
                lvl = frame_word[b];
                if (b * bit_period + n == flip_at)
                    lvl = ~lvl;
                send_level(lvl);
            end
    endtask

    // Stop offering and wait until every predicted result is back and the
    // input pipeline is empty; only then is a register write safe.
    task automatic settle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_period(input logic [COUNT_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        bit_period = int'(value);
        settings_made++;
    endtask

    // Idle line, then mostly clean frames with random bytes; some frames carry a
    // glitch, some stretches are plain line noise.
    task automatic line_traffic();
        int kind;
        send_held(1'b1, $urandom_range(1, 6));
        kind = $urandom_range(0, 19);
        if (kind < 14)
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, -1, 0);
        else if (kind < 17)
            send_frame(8'($urandom_range(0, 255)), 1'b1,
                       int'($urandom_range(0, FRAME_BITS * bit_period - 1)), 0);
        else
            repeat ($urandom_range(1, 30)) send_level(1'($urandom_range(0, 1)));
    endtask

    // Result sink: stalls on its own pattern, in stretches of one style each;
    // on request it holds off for HOLD_CYCLES so results pile up in the block.
    initial begin : result_sink
        int span, style, k;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(8, 64);
                for (k = 0; k < span && !hold_off_req; k++) begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= (k % 4 == 3);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase, phase_start, pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset period (868): start bit underway, then the period shrinks below
        // the count already reached, so the start bit ends on the next sample.
        send_held(1'b1, 2);
        send_held(1'b0, 4);
        settle();
        write_period(COUNT_WIDTH'(3));
        send_level(1'b0);
        send_frame(8'hA5, 1'b1, -1, 1);

        // Shortest period: byte extremes, low stop bit (still a clean frame),
        // glitch in the start bit, change on the very last sample of the frame.
        settle();
        write_period(COUNT_WIDTH'(2));
        send_held(1'b1, 2);
        send_frame(8'h00, 1'b1, -1, 0);
        send_held(1'b1, 1);
        send_frame(8'hFF, 1'b1, -1, 0);
        send_held(1'b1, 1);
        send_frame(8'h5A, 1'b0, -1, 0);
        send_held(1'b1, 2);
        send_frame(8'h3C, 1'b1, 1, 0);
        send_held(1'b1, 1);
        send_frame(8'hC3, 1'b1, FRAME_BITS * 2 - 1, 0);
        send_held(1'b1, 1);
        send_frame(8'h96, 1'b1, -1, 0);

        // Longest period: a start bit begins, then the period drops to 2 mid-bit.
        settle();
        write_period(16'hFFFF);
        send_held(1'b1, 1);
        send_held(1'b0, 5);
        settle();
        write_period(COUNT_WIDTH'(2));
        send_level(1'b0);
        send_frame(8'h81, 1'b1, -1, 1);

        // Random part, one period setting per phase. Phase 2 runs under the long
        // receiver hold-off; every phase boundary waits for all results.
        phase = 0;
        while (samples_sent < ITEMS) begin
            settle();
            case (phase % 8)
                0, 2:    pick = 2;
                1:       pick = 5;
                3:       pick = 3;
                5:       pick = 7;
                6:       pick = 4;
                default: pick = $urandom_range(2, 12);
            endcase
            write_period(COUNT_WIDTH'(pick));
            phase_start = samples_sent;
            if (phase == 2)
                hold_off_req = 1'b1;
            while (samples_sent - phase_start < PHASE_SAMPLES || hold_off_req)
                line_traffic();
            phase++;
        end

        s_tvalid <= 1'b0;
        while (frames_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d line samples over %0d period settings (868, 2 to 65535),",
                 samples_sent, settings_made + 1);
        $display("%0d frames compared, %0d of them flagged invalid.",
                 frames_checked, invalid_checked);
        if (frames_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, frames_pending);
        if (mismatches == 0 && frames_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial begin : run_limit
        #5000000;
        $display("%0t: run limit reached", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/ufd_pkg.sv
rtl/ufd_rx.sv
rtl/uart_frame_decoder.sv
tb/sv/uart_frame_checker.sv
tb/sv/tb_top.sv
